/* rtl/srtf_pkg.sv */
`default_nettype none

package srtf_pkg;

    localparam int TIME_W  = 24;
    localparam int SUM_W   = 30;
    localparam int ARR_W   = 16;
    localparam int REM_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // Request kinds carried on s_tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 168;
    localparam int M_TUSER_W = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SUM
    } state_t;

    // One task table row; all fields share one RAM word
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [REM_W-1:0]  remaining;
        logic              has_run;
        logic [TIME_W-1:0] last_end;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/srtf_ram.sv */
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/srtf_tick_scheduler.sv */
// Load request: written to the task RAM, no result; loads may follow back to back.
// Tick request: ST_SCAN reads n = min(task_count, MAX_TASKS) rows, one RAM row per cycle,
// then ST_UPDATE (skipped when nothing is left to run) and ST_SUM; the next request can
// be taken as the result appears, and ST_SUM holds while an earlier result is unaccepted.
// Reset (aresetn low, synchronous) clears control state, then a clearing pass zeroes all
// MAX_TASKS rows of the task RAM before the first request is taken.
`default_nettype none

module srtf_tick_scheduler #(
    parameter int MAX_TASKS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [srtf_pkg::CNT_W-1:0]     cfg_wdata,   // task_count
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [5:0] task_slot, [21:6] arrival, [37:22] burst
    input  wire logic [srtf_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,     // [0] mode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [5:0] task_id, [29:6] slice_start, [53:30] slice_end, [77:54] wait_increment,
    // [101:78] turnaround, [131:102] total_turnaround, [161:132] total_wait
    output logic      [srtf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [srtf_pkg::M_TUSER_W-1:0] m_tuser      // [0] finished, [1] all_done
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = srtf_pkg::TIME_W;
    localparam int SW = srtf_pkg::SUM_W;
    localparam int RW = srtf_pkg::REM_W;
    localparam int ARW = srtf_pkg::ARR_W;
    localparam int EW = $bits(srtf_pkg::entry_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TASKS - 1);

    srtf_pkg::state_t state_reg, state_next;

    logic [srtf_pkg::CNT_W-1:0] task_count_reg;
    logic [TW-1:0] cur_time_reg, cur_time_next;
    logic [SW-1:0] turn_sum_reg, turn_sum_next;
    logic [SW-1:0] wait_sum_reg, wait_sum_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          dv_reg, dv_next;
    logic [AW-1:0] didx_reg, didx_next;

    // scan trackers
    logic          any_reg, any_next;
    logic          fc_found_reg, fc_found_next;
    logic [AW-1:0] fc_idx_reg, fc_idx_next;
    logic [RW-1:0] fc_rem_reg, fc_rem_next;
    logic [ARW-1:0] ma_arr_reg, ma_arr_next;
    logic [AW-1:0] ma_idx_reg, ma_idx_next;
    logic [RW-1:0] ma_rem_reg, ma_rem_next;

    // pick and update results
    logic [AW-1:0] best_reg, best_next;
    logic [TW-1:0] t_reg, t_next;
    logic [TW-1:0] end_reg, end_next;
    logic [TW-1:0] wait_reg, wait_next;
    logic [TW-1:0] turn_reg, turn_next;
    logic          fin_reg, fin_next;
    logic          alldone_reg, alldone_next;

    logic                  m_valid_reg, m_valid_next;
    logic [srtf_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [srtf_pkg::M_TUSER_W-1:0] m_user_reg, m_user_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    srtf_pkg::entry_t ram_wdata;
    logic [EW-1:0] ram_rdata;
    srtf_pkg::entry_t rd_entry;

    logic [CW-1:0] n_used;

    logic [srtf_pkg::SLOT_W-1:0] in_slot;
    logic [ARW-1:0]              in_arrive;
    logic [RW-1:0]               in_service;

    assign in_slot    = s_tdata[5:0];
    assign in_arrive  = s_tdata[21:6];
    assign in_service = s_tdata[37:22];
    assign rd_entry   = srtf_pkg::entry_t'(ram_rdata);

    assign n_used = (32'(task_count_reg) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(task_count_reg);

    assign s_tready = (state_reg == srtf_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    srtf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_task_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (EW'(ram_wdata)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srtf_pkg::ST_CLEAR;
            task_count_reg <= '0;
            cur_time_reg   <= '0;
            turn_sum_reg   <= '0;
            wait_sum_reg   <= '0;
            clr_idx_reg    <= '0;
            rd_idx_reg     <= '0;
            dv_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                task_count_reg <= cfg_wdata;
            end
            cur_time_reg <= cur_time_next;
            turn_sum_reg <= turn_sum_next;
            wait_sum_reg <= wait_sum_next;
            clr_idx_reg  <= clr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            dv_reg       <= dv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        didx_reg      <= didx_next;
        any_reg       <= any_next;
        fc_found_reg  <= fc_found_next;
        fc_idx_reg    <= fc_idx_next;
        fc_rem_reg    <= fc_rem_next;
        ma_arr_reg    <= ma_arr_next;
        ma_idx_reg    <= ma_idx_next;
        ma_rem_reg    <= ma_rem_next;
        best_reg      <= best_next;
        t_reg         <= t_next;
        end_reg       <= end_next;
        wait_reg      <= wait_next;
        turn_reg      <= turn_next;
        fin_reg       <= fin_next;
        alldone_reg   <= alldone_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    always_comb begin
        logic          unfinished;
        logic [TW-1:0] arr_ext;
        logic [TW-1:0] base;
        logic [TW-1:0] end_t;
        logic [RW-1:0] rem_new;
        logic [SW:0]   tsum;
        logic [SW:0]   wsum;
        logic [SW-1:0] tsum_sat;
        logic [SW-1:0] wsum_sat;

        state_next    = state_reg;
        cur_time_next = cur_time_reg;
        turn_sum_next = turn_sum_reg;
        wait_sum_next = wait_sum_reg;
        clr_idx_next  = clr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        dv_next       = 1'b0;
        didx_next     = didx_reg;
        any_next      = any_reg;
        fc_found_next = fc_found_reg;
        fc_idx_next   = fc_idx_reg;
        fc_rem_next   = fc_rem_reg;
        ma_arr_next   = ma_arr_reg;
        ma_idx_next   = ma_idx_reg;
        ma_rem_next   = ma_rem_reg;
        best_next     = best_reg;
        t_next        = t_reg;
        end_next      = end_reg;
        wait_next     = wait_reg;
        turn_next     = turn_reg;
        fin_next      = fin_reg;
        alldone_next  = alldone_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        unfinished = (rd_entry.remaining != '0);
        arr_ext    = TW'(rd_entry.arrival);
        base       = rd_entry.has_run ? rd_entry.last_end : arr_ext;
        end_t      = (t_reg < srtf_pkg::TIME_MAX) ? t_reg + TW'(1) : srtf_pkg::TIME_MAX;
        rem_new    = rd_entry.remaining - RW'(1);

        tsum     = {1'b0, turn_sum_reg} + (SW + 1)'(turn_reg);
        wsum     = {1'b0, wait_sum_reg} + (SW + 1)'(wait_reg);
        tsum_sat = tsum[SW] ? srtf_pkg::SUM_MAX : tsum[SW-1:0];
        wsum_sat = wsum[SW] ? srtf_pkg::SUM_MAX : wsum[SW-1:0];

        unique case (state_reg)
            srtf_pkg::ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == LAST_ADDR) begin
                    state_next = srtf_pkg::ST_IDLE;
                end
            end

            srtf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == srtf_pkg::MODE_LOAD) begin
                        // drop loads to slots outside the table
                        if (32'(in_slot) < MAX_TASKS) begin
                            ram_we              = 1'b1;
                            ram_waddr           = AW'(in_slot);
                            ram_wdata.arrival   = in_arrive;
                            ram_wdata.remaining = in_service;
                            ram_wdata.has_run   = 1'b0;
                        end
                    end else begin
                        rd_idx_next   = '0;
                        any_next      = 1'b0;
                        fc_found_next = 1'b0;
                        state_next    = srtf_pkg::ST_SCAN;
                    end
                end
            end

            srtf_pkg::ST_SCAN: begin
                // fold in the row read last cycle
                if (dv_reg && unfinished) begin
                    any_next = 1'b1;
                    if (arr_ext <= cur_time_reg) begin
                        if (!fc_found_reg || rd_entry.remaining < fc_rem_reg) begin
                            fc_found_next = 1'b1;
                            fc_idx_next   = didx_reg;
                            fc_rem_next   = rd_entry.remaining;
                        end
                    end
                    if (!any_reg || rd_entry.arrival < ma_arr_reg) begin
                        ma_arr_next = rd_entry.arrival;
                        ma_idx_next = didx_reg;
                        ma_rem_next = rd_entry.remaining;
                    end else if (rd_entry.arrival == ma_arr_reg
                                 && rd_entry.remaining < ma_rem_reg) begin
                        ma_idx_next = didx_reg;
                        ma_rem_next = rd_entry.remaining;
                    end
                end

                if (rd_idx_reg < n_used) begin
                    ram_raddr   = rd_idx_reg[AW-1:0];
                    didx_next   = rd_idx_reg[AW-1:0];
                    dv_next     = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                end else if (!dv_reg) begin
                    if (!any_reg) begin
                        best_next    = '0;
                        t_next       = cur_time_reg;
                        end_next     = cur_time_reg;
                        wait_next    = '0;
                        turn_next    = '0;
                        fin_next     = 1'b0;
                        alldone_next = 1'b1;
                        state_next   = srtf_pkg::ST_SUM;
                    end else begin
                        // nothing arrived yet: jump to the earliest arrival
                        if (TW'(ma_arr_reg) > cur_time_reg) begin
                            best_next = ma_idx_reg;
                            t_next    = TW'(ma_arr_reg);
                        end else begin
                            best_next = fc_idx_reg;
                            t_next    = cur_time_reg;
                        end
                        ram_raddr  = best_next;
                        state_next = srtf_pkg::ST_UPDATE;
                    end
                end
            end

            srtf_pkg::ST_UPDATE: begin
                wait_next     = (t_reg >= base) ? t_reg - base : '0;
                end_next      = end_t;
                cur_time_next = end_t;
                fin_next      = (rem_new == '0);
                turn_next     = (rem_new == '0 && end_t >= arr_ext) ? end_t - arr_ext : '0;
                alldone_next  = 1'b0;

                ram_we              = 1'b1;
                ram_waddr           = best_reg;
                ram_wdata.arrival   = rd_entry.arrival;
                ram_wdata.remaining = rem_new;
                ram_wdata.has_run   = 1'b1;
                ram_wdata.last_end  = end_t;
                state_next          = srtf_pkg::ST_SUM;
            end

            srtf_pkg::ST_SUM: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    turn_sum_next = tsum_sat;
                    wait_sum_next = wsum_sat;
                    m_data_next   = {6'b0, wsum_sat, tsum_sat, turn_reg, wait_reg,
                                     end_reg, t_reg, 6'(best_reg)};
                    m_user_next   = {alldone_reg, fin_reg};
                    m_valid_next  = 1'b1;
                    state_next    = srtf_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = srtf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
